// ===== rtl/kalman_measurement_update_macros.svh =====
// ----------------------------------------------------------------------------
// Kalman measurement update assertion macros
// Concurrent check helpers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef KALMAN_MEASUREMENT_UPDATE_MACROS_SVH
`define KALMAN_MEASUREMENT_UPDATE_MACROS_SVH
`ifndef SYNTHESIS
`define KMU_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("same-cycle check failed");
`define KMU_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle check failed");
`else
`define KMU_ASSERT_IMP(label, clk, rst_n, a, b)
`define KMU_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/kmu_pkg.sv =====
// ----------------------------------------------------------------------------
// Kalman measurement update package
// Item types, register indexes, controller states, datapath commands and
// saturation helpers shared by the modules of the block.
// ----------------------------------------------------------------------------
package kmu_pkg;

	typedef struct packed {
		logic signed [31:0] measurement;
		logic               start_fresh;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] estimate;
		logic [2:0]         estimate_index;
		logic               last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [3:0]  dim_in_use;
		logic [30:0] process_noise;
		logic [30:0] measurement_noise;
		logic [30:0] initial_covariance;
	} cfg_t;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIM = 2'd0,
		REG_Q   = 2'd1,
		REG_R   = 2'd2,
		REG_P0  = 2'd3
	} cfg_reg_t;

	localparam logic [3:0]  DIM_RESET = 4'd4;
	localparam logic [30:0] Q_RESET   = 31'd32768;
	localparam logic [30:0] R_RESET   = 31'd32768;
	localparam logic [30:0] P0_RESET  = 31'd65536;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_STORE,
		ST_G_RDD, ST_G_DEN, ST_G_RDP, ST_G_NUM, ST_G_DIV,
		ST_V_RD, ST_V_WR,
		ST_S_RD, ST_S_MUL, ST_S_ACC, ST_S_RDX, ST_S_WRX,
		ST_C_RD, ST_C_MUL, ST_C_ACC, ST_C_WRT,
		ST_W_RD, ST_W_WR,
		ST_O_RD, ST_O_LOAD, ST_O_WAIT
	} state_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_CLEAR, OP_RELOAD, OP_STORE,
		OP_DIAG_RD, OP_DEN, OP_GAIN_NUM, OP_GAIN_DIV,
		OP_INNOV_RD, OP_INNOV_WR,
		OP_MUL_X, OP_MUL_P, OP_ACC, OP_X_WR,
		OP_COL_RD, OP_T_WR, OP_P_WR, OP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   capture;
		logic   last;
	} dp_cmd_t;

	typedef struct packed {
		logic den_zero;
		logic div_done;
	} dp_status_t;

	function automatic logic signed [31:0] sat33(input logic [32:0] v);
		logic signed [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat64(input logic [63:0] v);
		logic signed [31:0] r;
		if (!(&v[63:31]) && (|v[63:31])) begin
			r = v[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/kalman_measurement_update.sv =====
// ----------------------------------------------------------------------------
// Kalman measurement update
// Collects measurement elements, runs an identity-transition Kalman update
// in signed fixed point and returns the updated estimate elements.
//
// Channel   Direction  Handshake                Payload
// in        sink       in_valid / in_stall      in_item (in_item_t)
// out       source     out_valid / out_stall    out_item (out_item_t)
// cfg       sink       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// An element that does not complete a run is only stored; a start flag first
// reloads the covariance memory. A completing element runs the update on one
// multiplier and one bit-serial divider: the gain pass, then the innovation,
// state and covariance passes over the n elements of the run, then the estimate
// elements are returned one at a time, each held while out_stall is high.
// After reset the covariance memory is cleared with in_stall high. Inputs are
// stalled until the last result is taken.
// ----------------------------------------------------------------------------
`include "kalman_measurement_update_macros.svh"

module kalman_measurement_update
	import kmu_pkg::*;
#(
	parameter int MAX_DIM   = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);
	localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	cfg_t          cfg_q;
	dp_cmd_t       cmd;
	dp_status_t    status;
	logic [IW-1:0] ci, cj, cl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dim_in_use         <= DIM_RESET;
			cfg_q.process_noise      <= Q_RESET;
			cfg_q.measurement_noise  <= R_RESET;
			cfg_q.initial_covariance <= P0_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_DIM: cfg_q.dim_in_use         <= cfg_data[3:0];
				REG_Q:   cfg_q.process_noise      <= cfg_data[30:0];
				REG_R:   cfg_q.measurement_noise  <= cfg_data[30:0];
				REG_P0:  cfg_q.initial_covariance <= cfg_data[30:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	kmu_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.dim_in_use(cfg_q.dim_in_use),
		.in_valid  (in_valid),
		.in_start  (in_item.start_fresh),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd),
		.ci        (ci),
		.cj        (cj),
		.cl        (cl)
	);

	kmu_dp #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd        (cmd),
		.ci         (ci),
		.cj         (cj),
		.cl         (cl),
		.measurement(in_item.measurement),
		.status     (status),
		.out_item   (out_item)
	);

	// No new element is taken while results of the current run are pending.
	`KMU_ASSERT_IMP(a_no_input_during_output, clk, arst_n, out_valid, in_stall)
	`KMU_ASSERT_NXT(a_input_then_busy, clk, arst_n, in_valid && !in_stall, in_stall)
	`KMU_ASSERT_NXT(a_last_ends_run, clk, arst_n, out_valid && !out_stall && out_item.last_of_run, !out_valid)
endmodule

// ===== rtl/kmu_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write and one registered read per cycle at a shared address.
// ----------------------------------------------------------------------------
module kmu_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [W-1:0]                               wdata,
	output logic [W-1:0]                               rdata
);
	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/kmu_div.sv =====
// ----------------------------------------------------------------------------
// Kalman gain divider
// Restoring divider, one quotient bit per cycle, fixed-point quotient
// rounded to nearest with ties away from zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module kmu_div
	import kmu_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [32:0] den,
	output logic               done,
	output logic signed [31:0] quo
);
	localparam int NW = 32 + FRAC_BITS;
	localparam int CNW = $clog2(NW + 1);
	localparam logic [NW:0] LIM_POS = (NW+1)'(32'h7FFF_FFFF);
	localparam logic [NW:0] LIM_NEG = (NW+1)'(33'h0_8000_0000);

	logic            busy_q;
	logic            done_q;
	logic [CNW-1:0]  cnt_q;
	logic [NW-1:0]   dvd_q;
	logic [32:0]     rem_q;
	logic [31:0]     den_q;
	logic            neg_q;

	logic [31:0] num_mag;
	logic [32:0] den_abs;
	logic [32:0] shifted;
	logic        fits;
	logic        round_up;
	logic [NW:0] mag;
	logic [NW:0] neg_mag;

	assign num_mag = num[31] ? (~num + 32'd1) : num;
	assign den_abs = den[32] ? (~den + 33'd1) : den;
	assign shifted = {rem_q[31:0], dvd_q[NW-1]};
	assign fits    = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num_mag, FRAC_BITS'(0)};
			rem_q <= '0;
			den_q <= den_abs[31:0];
			neg_q <= num[31] ^ den[32];
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= shifted - {1'b0, den_q};
				dvd_q <= {dvd_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				dvd_q <= {dvd_q[NW-2:0], 1'b0};
			end
		end
	end

	// Round up when twice the remainder reaches the divisor.
	assign round_up = ({rem_q[31:0], 1'b0} >= {1'b0, den_q});
	assign mag      = {1'b0, dvd_q} + (NW+1)'(round_up);
	assign neg_mag  = ~mag + 1'b1;

	always_comb begin
		if (neg_q) begin
			quo = (mag > LIM_NEG) ? 32'sh8000_0000 : neg_mag[31:0];
		end else begin
			quo = (mag > LIM_POS) ? 32'sh7FFF_FFFF : mag[31:0];
		end
	end

	assign done = done_q;
endmodule

// ===== rtl/kmu_dp.sv =====
// ----------------------------------------------------------------------------
// Kalman measurement update datapath
// Covariance, gain, state, measurement and column memories, one shared
// multiplier with rounding accumulator, and the gain divider.
// ----------------------------------------------------------------------------
module kmu_dp
	import kmu_pkg::*;
#(
	parameter int MAX_DIM   = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  cfg_t                                        cfg,
	input  dp_cmd_t                                     cmd,
	input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] ci,
	input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] cj,
	input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] cl,
	input  logic signed [31:0]                          measurement,
	output dp_status_t                                  status,
	output out_item_t                                   out_item
);
	localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int VEC_DEPTH = 1 << IW;
	localparam int MAT_DEPTH = 1 << (2 * IW);
	localparam logic [32:0] ONE  = 33'(64'd1 << FRAC_BITS);
	localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

	logic signed [31:0] meas_q;
	logic signed [32:0] den_q;
	logic [63:0]        acc_q;
	logic [63:0]        prod_s1;
	logic               neg_s1;
	out_item_t          out_q;

	logic [2*IW-1:0] p_addr, k_addr;
	logic [IW-1:0]   x_addr;
	logic            p_we, k_we, x_we, z_we, t_we;
	logic [31:0]     p_wdata, k_wdata, x_wdata, z_wdata, t_wdata;
	logic [31:0]     p_rd, k_rd, x_rd, z_rd, t_rd;

	logic               diag_g;
	logic signed [31:0] p1_g;
	logic signed [32:0] den_n;
	logic               div_done;
	logic signed [31:0] div_quo;
	logic               den_zero;
	logic [31:0]        p0_val;

	logic signed [31:0] opa, opb;
	logic [31:0]        ma, mb;
	logic [63:0]        rnd;

	assign den_zero = (den_q == 33'sd0);
	assign status   = '{den_zero: den_zero, div_done: div_done};

	always_comb begin
		case (cmd.op)
			OP_DIAG_RD: p_addr = {cj, cj};
			OP_COL_RD:  p_addr = {cl, cj};
			default:    p_addr = {ci, cj};
		endcase
		k_addr = (cmd.op == OP_COL_RD) ? {ci, cl} : {ci, cj};
		x_addr = ((cmd.op == OP_INNOV_RD) || (cmd.op == OP_INNOV_WR)) ? cj : ci;
	end

	// Diagonal of the predicted covariance gets the process noise added.
	assign diag_g = (cmd.op == OP_DEN) || (ci == cj);
	assign p1_g   = sat33({p_rd[31], p_rd} + (diag_g ? {2'b00, cfg.process_noise} : 33'd0));
	assign den_n  = {p1_g[31], p1_g} + {2'b00, cfg.measurement_noise};
	assign p0_val = (cmd.op == OP_CLEAR) ? {1'b0, P0_RESET} : {1'b0, cfg.initial_covariance};

	always_comb begin
		p_we    = 1'b0;
		p_wdata = t_rd;
		x_we    = 1'b0;
		x_wdata = sat64({{32{x_rd[31]}}, x_rd} + acc_q);
		z_we    = 1'b0;
		z_wdata = meas_q;
		k_we    = 1'b0;
		k_wdata = den_zero ? 32'd0 : div_quo;
		t_we    = 1'b0;
		t_wdata = sat64(acc_q);
		case (cmd.op)
			OP_CLEAR, OP_RELOAD: begin
				p_we    = 1'b1;
				p_wdata = (ci == cj) ? p0_val : 32'd0;
				x_we    = (cj == '0);
				x_wdata = 32'd0;
			end
			OP_STORE:    z_we = 1'b1;
			OP_INNOV_WR: begin
				z_we    = 1'b1;
				z_wdata = sat33({z_rd[31], z_rd} - {x_rd[31], x_rd});
			end
			OP_GAIN_NUM: k_we = den_zero;
			OP_GAIN_DIV: k_we = div_done;
			OP_X_WR:     x_we = 1'b1;
			OP_T_WR:     t_we = 1'b1;
			OP_P_WR:     p_we = 1'b1;
			default: begin
			end
		endcase
	end

	// Multiplier operands: gain times innovation, or (I - K) times P1.
	always_comb begin
		if (cmd.op == OP_MUL_P) begin
			opa = sat33(((ci == cl) ? ONE : 33'd0) - {k_rd[31], k_rd});
			opb = sat33({p_rd[31], p_rd} +
				((cl == cj) ? {2'b00, cfg.process_noise} : 33'd0));
		end else begin
			opa = k_rd;
			opb = z_rd;
		end
		ma = opa[31] ? (~opa + 32'd1) : opa;
		mb = opb[31] ? (~opb + 32'd1) : opb;
	end

	assign rnd = (prod_s1 + HALF) >> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			case (cmd.op)
				OP_ACC:           acc_q <= acc_q + (neg_s1 ? (~rnd + 64'd1) : rnd);
				OP_X_WR, OP_T_WR: acc_q <= '0;
				default:          acc_q <= acc_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			meas_q <= measurement;
		end
		if (cmd.op == OP_DEN) begin
			den_q <= den_n;
		end
		if ((cmd.op == OP_MUL_X) || (cmd.op == OP_MUL_P)) begin
			prod_s1 <= ma * mb;
			neg_s1  <= opa[31] ^ opb[31];
		end
		if (cmd.op == OP_OUT_LOAD) begin
			out_q.estimate       <= x_rd;
			out_q.estimate_index <= 3'(ci);
			out_q.last_of_run    <= cmd.last;
		end
	end

	assign out_item = out_q;

	kmu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start ((cmd.op == OP_GAIN_NUM) && !den_zero),
		.num   (p1_g),
		.den   (den_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	kmu_ram #(.W(32), .DEPTH(MAT_DEPTH)) u_cov (
		.clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rd)
	);

	kmu_ram #(.W(32), .DEPTH(MAT_DEPTH)) u_gain (
		.clk(clk), .we(k_we), .addr(k_addr), .wdata(k_wdata), .rdata(k_rd)
	);

	kmu_ram #(.W(32), .DEPTH(VEC_DEPTH)) u_state (
		.clk(clk), .we(x_we), .addr(x_addr), .wdata(x_wdata), .rdata(x_rd)
	);

	// Holds the measurements, then is overwritten with the innovation.
	kmu_ram #(.W(32), .DEPTH(VEC_DEPTH)) u_meas (
		.clk(clk), .we(z_we), .addr(cj), .wdata(z_wdata), .rdata(z_rd)
	);

	kmu_ram #(.W(32), .DEPTH(VEC_DEPTH)) u_col (
		.clk(clk), .we(t_we), .addr(ci), .wdata(t_wdata), .rdata(t_rd)
	);
endmodule

// ===== rtl/kmu_ctrl.sv =====
// ----------------------------------------------------------------------------
// Kalman measurement update controller
// Sequences clearing and reloading, element storage, gain, innovation, state and
// covariance passes and the result handshake.
// ----------------------------------------------------------------------------
module kmu_ctrl
	import kmu_pkg::*;
#(
	parameter int MAX_DIM = 8
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic [3:0]                                  dim_in_use,
	input  logic                                        in_valid,
	input  logic                                        in_start,
	output logic                                        in_stall,
	output logic                                        out_valid,
	input  logic                                        out_stall,
	input  dp_status_t                                  status,
	output dp_cmd_t                                     cmd,
	output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] ci,
	output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] cj,
	output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] cl
);
	localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CW = $clog2(MAX_DIM + 1) > IW ? $clog2(MAX_DIM + 1) : IW;
	localparam logic [IW-1:0] SWEEP_LAST = IW'(MAX_DIM - 1);

	state_t        state_q, state_n;
	logic [IW-1:0] i_q, i_n, j_q, j_n, l_q, l_n, nl_q, nl_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic          rst_clr_q, rst_clr_n;

	logic          over_dim;
	logic [IW-1:0] nl_cur;
	logic          i_last, j_last, l_last;

	assign over_dim = ({28'd0, dim_in_use} > 32'(MAX_DIM));
	assign nl_cur   = (dim_in_use == 4'd0) ? '0 :
		(over_dim ? SWEEP_LAST : IW'(dim_in_use - 4'd1));
	assign i_last = (i_q == nl_q);
	assign j_last = (j_q == nl_q);
	assign l_last = (l_q == nl_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			i_q       <= '0;
			j_q       <= '0;
			l_q       <= '0;
			nl_q      <= '0;
			cnt_q     <= '0;
			rst_clr_q <= 1'b1;
		end else begin
			state_q   <= state_n;
			i_q       <= i_n;
			j_q       <= j_n;
			l_q       <= l_n;
			nl_q      <= nl_n;
			cnt_q     <= cnt_n;
			rst_clr_q <= rst_clr_n;
		end
	end

	always_comb begin
		state_n     = state_q;
		i_n         = i_q;
		j_n         = j_q;
		l_n         = l_q;
		nl_n        = nl_q;
		cnt_n       = cnt_q;
		rst_clr_n   = rst_clr_q;
		cmd.op      = OP_NOP;
		cmd.capture = 1'b0;
		cmd.last    = 1'b0;
		in_stall    = 1'b1;
		out_valid   = 1'b0;
		ci          = i_q;
		cj          = j_q;
		cl          = l_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.op = rst_clr_q ? OP_CLEAR : OP_RELOAD;
				if (j_q == SWEEP_LAST) begin
					j_n = '0;
					if (i_q == SWEEP_LAST) begin
						i_n       = '0;
						rst_clr_n = 1'b0;
						state_n   = rst_clr_q ? ST_IDLE : ST_STORE;
					end else begin
						i_n = i_q + 1'b1;
					end
				end else begin
					j_n = j_q + 1'b1;
				end
			end
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
				if (in_valid) begin
					nl_n = nl_cur;
					i_n  = '0;
					j_n  = '0;
					l_n  = '0;
					if (in_start) begin
						cnt_n   = '0;
						state_n = ST_CLEAR;
					end else begin
						state_n = ST_STORE;
					end
				end
			end
			ST_STORE: begin
				cmd.op = OP_STORE;
				cj     = cnt_q[IW-1:0];
				if (cnt_q >= CW'(nl_q)) begin
					cnt_n   = '0;
					state_n = ST_G_RDD;
				end else begin
					cnt_n   = cnt_q + 1'b1;
					state_n = ST_IDLE;
				end
			end
			ST_G_RDD: begin
				cmd.op  = OP_DIAG_RD;
				state_n = ST_G_DEN;
			end
			ST_G_DEN: begin
				cmd.op  = OP_DEN;
				i_n     = '0;
				state_n = ST_G_RDP;
			end
			ST_G_RDP: state_n = ST_G_NUM;
			ST_G_NUM, ST_G_DIV: begin
				cmd.op = (state_q == ST_G_NUM) ? OP_GAIN_NUM : OP_GAIN_DIV;
				if ((state_q == ST_G_NUM) && !status.den_zero) begin
					state_n = ST_G_DIV;
				end else if ((state_q == ST_G_NUM) || status.div_done) begin
					if (i_last) begin
						i_n = '0;
						if (j_last) begin
							j_n     = '0;
							state_n = ST_V_RD;
						end else begin
							j_n     = j_q + 1'b1;
							state_n = ST_G_RDD;
						end
					end else begin
						i_n     = i_q + 1'b1;
						state_n = ST_G_RDP;
					end
				end
			end
			ST_V_RD: begin
				cmd.op  = OP_INNOV_RD;
				state_n = ST_V_WR;
			end
			ST_V_WR: begin
				cmd.op = OP_INNOV_WR;
				if (j_last) begin
					j_n     = '0;
					i_n     = '0;
					state_n = ST_S_RD;
				end else begin
					j_n     = j_q + 1'b1;
					state_n = ST_V_RD;
				end
			end
			ST_S_RD:  state_n = ST_S_MUL;
			ST_S_MUL: begin
				cmd.op  = OP_MUL_X;
				state_n = ST_S_ACC;
			end
			ST_S_ACC: begin
				cmd.op = OP_ACC;
				if (j_last) begin
					j_n     = '0;
					state_n = ST_S_RDX;
				end else begin
					j_n     = j_q + 1'b1;
					state_n = ST_S_RD;
				end
			end
			ST_S_RDX: state_n = ST_S_WRX;
			ST_S_WRX: begin
				cmd.op = OP_X_WR;
				if (i_last) begin
					i_n     = '0;
					j_n     = '0;
					l_n     = '0;
					state_n = ST_C_RD;
				end else begin
					i_n     = i_q + 1'b1;
					state_n = ST_S_RD;
				end
			end
			ST_C_RD: begin
				cmd.op  = OP_COL_RD;
				state_n = ST_C_MUL;
			end
			ST_C_MUL: begin
				cmd.op  = OP_MUL_P;
				state_n = ST_C_ACC;
			end
			ST_C_ACC: begin
				cmd.op = OP_ACC;
				if (l_last) begin
					l_n     = '0;
					state_n = ST_C_WRT;
				end else begin
					l_n     = l_q + 1'b1;
					state_n = ST_C_RD;
				end
			end
			ST_C_WRT: begin
				cmd.op = OP_T_WR;
				if (i_last) begin
					i_n     = '0;
					state_n = ST_W_RD;
				end else begin
					i_n     = i_q + 1'b1;
					state_n = ST_C_RD;
				end
			end
			ST_W_RD:  state_n = ST_W_WR;
			ST_W_WR: begin
				// A column is written back only after all its rows are done.
				cmd.op = OP_P_WR;
				if (i_last) begin
					i_n = '0;
					if (j_last) begin
						j_n     = '0;
						state_n = ST_O_RD;
					end else begin
						j_n     = j_q + 1'b1;
						state_n = ST_C_RD;
					end
				end else begin
					i_n     = i_q + 1'b1;
					state_n = ST_W_RD;
				end
			end
			ST_O_RD:  state_n = ST_O_LOAD;
			ST_O_LOAD: begin
				cmd.op   = OP_OUT_LOAD;
				cmd.last = i_last;
				state_n  = ST_O_WAIT;
			end
			ST_O_WAIT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (i_last) begin
						i_n     = '0;
						state_n = ST_IDLE;
					end else begin
						i_n     = i_q + 1'b1;
						state_n = ST_O_RD;
					end
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end
endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Kalman measurement update testbench
// Drives measurement items, register writes and random stalls into the block
// and checks every estimate item against a fixed-point model of the update.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import kmu_pkg::*;

	localparam int NDIM = 8;

	class filter_scoreboard;
		logic [3:0]         dim_reg;
		logic [30:0]        q_reg, r_reg, p0_reg;
		logic signed [31:0] est[NDIM];
		logic signed [31:0] cov[NDIM*NDIM];
		logic signed [31:0] meas[NDIM];
		logic signed [31:0] gain[NDIM*NDIM];
		int unsigned        meas_count;
		out_item_t          pending_estimates[$];
		int                 errors;

		function new();
			dim_reg = DIM_RESET;
			q_reg = Q_RESET;
			r_reg = R_RESET;
			p0_reg = P0_RESET;
			meas_count = 0;
			errors = 0;
			reload();
		endfunction

		function void reload();
			for (int i = 0; i < NDIM; i++) begin
				est[i] = 0;
				for (int j = 0; j < NDIM; j++)
					cov[i*NDIM+j] = (i == j) ? $signed({1'b0, p0_reg}) : 0;
			end
		endfunction

		function logic signed [31:0] clip(longint v);
			if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
			if (v < -64'sd2147483648) return 32'sh8000_0000;
			return v[31:0];
		endfunction

		function longint unsigned magnitude(longint v);
			return (v < 0) ? -v : v;
		endfunction

		// Product rounded to nearest, ties away from zero.
		function longint fx_mul(longint a, longint b);
			longint unsigned prod;
			prod = (magnitude(a) * magnitude(b) + 64'd32768) >> 16;
			return ((a < 0) != (b < 0)) ? -longint'(prod) : longint'(prod);
		endfunction

		function longint fx_div(longint n, longint d);
			longint unsigned num, den, quo;
			num = magnitude(n) << 16;
			den = magnitude(d);
			quo = (2 * num + den) / (2 * den);
			return ((n < 0) != (d < 0)) ? -longint'(quo) : longint'(quo);
		endfunction

		function void write_reg(cfg_reg_t idx, logic [31:0] d);
			case (idx)
				REG_DIM: dim_reg = d[3:0];
				REG_Q:   q_reg = d[30:0];
				REG_R:   r_reg = d[30:0];
				REG_P0:  p0_reg = d[30:0];
				default: begin
				end
			endcase
		endfunction

		function void run_update(int n);
			logic signed [31:0] p1[NDIM*NDIM];
			logic signed [31:0] innov[NDIM];
			longint acc, den;
			logic signed [31:0] ikl;
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++)
					p1[i*NDIM+j] = clip(longint'(cov[i*NDIM+j]) +
						((i == j) ? longint'(q_reg) : 0));
			for (int j = 0; j < n; j++) begin
				den = longint'(p1[j*NDIM+j]) + longint'(r_reg);
				for (int i = 0; i < n; i++)
					gain[i*NDIM+j] = (den == 0) ? 0 : clip(fx_div(p1[i*NDIM+j], den));
			end
			for (int j = 0; j < n; j++)
				innov[j] = clip(longint'(meas[j]) - longint'(est[j]));
			for (int i = 0; i < n; i++) begin
				acc = 0;
				for (int j = 0; j < n; j++)
					acc += fx_mul(gain[i*NDIM+j], innov[j]);
				est[i] = clip(longint'(est[i]) + acc);
			end
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++) begin
					acc = 0;
					for (int l = 0; l < n; l++) begin
						ikl = clip(((i == l) ? 64'sd65536 : 0) - longint'(gain[i*NDIM+l]));
						acc += fx_mul(ikl, p1[l*NDIM+j]);
					end
					cov[i*NDIM+j] = clip(acc);
				end
		endfunction

		function void note_input(in_item_t it);
			int n;
			out_item_t o;
			n = (dim_reg == 0) ? 1 : (dim_reg > NDIM) ? NDIM : dim_reg;
			if (it.start_fresh) begin
				reload();
				meas_count = 0;
			end
			if (meas_count >= NDIM) meas_count = 0;
			meas[meas_count] = it.measurement;
			meas_count++;
			if (meas_count < n) return;
			run_update(n);
			meas_count = 0;
			for (int i = 0; i < n; i++) begin
				o.estimate = est[i];
				o.estimate_index = i[2:0];
				o.last_of_run = (i == n - 1);
				pending_estimates.push_back(o);
			end
		endfunction

		function void check(out_item_t got);
			out_item_t exp_item;
			if (pending_estimates.size() == 0) begin
				$display("%0t: unexpected estimate item %h", $realtime, got);
				errors++;
				return;
			end
			exp_item = pending_estimates.pop_front();
			if (got.estimate !== exp_item.estimate) begin
				$display("%0t: estimate expected %h actual %h", $realtime,
					exp_item.estimate, got.estimate);
				errors++;
			end
			if (got.estimate_index !== exp_item.estimate_index) begin
				$display("%0t: estimate_index expected %0d actual %0d", $realtime,
					exp_item.estimate_index, got.estimate_index);
				errors++;
			end
			if (got.last_of_run !== exp_item.last_of_run) begin
				$display("%0t: last_of_run expected %0b actual %0b", $realtime,
					exp_item.last_of_run, got.last_of_run);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_item;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_item;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	filter_scoreboard sb = new();
	bit tx_no_gaps;
	bit rx_no_gaps;
	bit long_hold;

	kalman_measurement_update DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

	// Result side: one stall draw per item, or a long hold when requested.
	initial begin
		int k;
		out_stall = 1'b0;
		forever begin
			if (long_hold) begin
				k = 600;
				long_hold = 0;
			end else begin
				k = rx_no_gaps ? 0 : $urandom_range(0, 13);
			end
			if (k > 0) begin
				out_stall <= 1'b1;
				repeat (k) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			sb.check(out_item);
		end
	end

	task automatic send(input logic signed [31:0] m, input logic sf);
		int gap;
		gap = tx_no_gaps ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{measurement: m, start_fresh: sf};
		do @(posedge clk); while (in_stall);
		sb.note_input('{measurement: m, start_fresh: sf});
	endtask

	// Waits for every estimate, then lets a reload or store finish.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending_estimates.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, d);
	endtask

	function automatic logic [31:0] noise_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF | {1'($urandom_range(0, 1)), 31'd0};
			1: return {1'($urandom_range(0, 1)), 31'd0};
			2: return $urandom;
			default: return $urandom_range(0, 32'h0004_0000) |
				{1'($urandom_range(0, 1)), 31'd0};
		endcase
	endfunction

	function automatic logic signed [31:0] rand_meas();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3: return $urandom;
			default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
		endcase
	endfunction

	initial begin
		int d;
		int items;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_DIM;
		cfg_data = '0;
		tx_no_gaps = 0;
		rx_no_gaps = 0;
		long_hold = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Extremes with the reset settings, then a restart in the middle of a run.
		send(32'sh7FFF_FFFF, 1'b1);
		send(32'sh8000_0000, 1'b0);
		send(32'sh0000_0000, 1'b0);
		send(-32'sd1, 1'b0);
		send(32'sh0001_0000, 1'b0);
		send(32'sh0002_0000, 1'b1);
		send(32'sh0003_0000, 1'b0);
		send(32'sh0004_0000, 1'b0);
		send(32'sh0005_0000, 1'b0);
		send(32'sh0006_0000, 1'b0);
		// Dimension lowered while two elements are already held.
		send(32'sh0000_8000, 1'b1);
		send(-32'sh0000_8000, 1'b0);
		wait_idle();
		write_reg(REG_DIM, 32'd2);
		send(32'sh0001_8000, 1'b0);
		wait_idle();
		// Zero divisor: no noise and no initial covariance.
		write_reg(REG_Q, 32'd0);
		write_reg(REG_R, 32'd0);
		write_reg(REG_P0, 32'd0);
		write_reg(REG_DIM, 32'd1);
		send(32'sh0012_3456, 1'b1);
		send(32'sh8000_0000, 1'b0);
		wait_idle();
		// Dimension zero acts as one; full-scale noise values.
		write_reg(REG_DIM, 32'hFFFF_FFF0);
		write_reg(REG_Q, 32'hFFFF_FFFF);
		write_reg(REG_R, 32'h7FFF_FFFF);
		write_reg(REG_P0, 32'hFFFF_FFFF);
		send(32'sh7FFF_FFFF, 1'b1);
		send(-32'sd5, 1'b0);
		wait_idle();
		// Dimension above the maximum acts as the maximum.
		write_reg(REG_DIM, 32'd15);
		for (int i = 0; i < 8; i++) send(rand_meas(), i == 0);
		wait_idle();

		items = 0;
		for (int ph = 0; items < 380; ph++) begin
			d = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
			if (ph == 3) d = 8;
			write_reg(REG_DIM, {28'($urandom), 4'(d)});
			write_reg(REG_Q, noise_value());
			write_reg(REG_R, noise_value());
			write_reg(REG_P0, noise_value());
			tx_no_gaps = ($urandom_range(0, 3) == 0);
			rx_no_gaps = ($urandom_range(0, 3) == 0);
			if (ph == 2) long_hold = 1;
			for (int i = 0; i < 24; i++) begin
				// Runs sometimes restart at their first element; a stray restart
				// now and then breaks a run.
				send(rand_meas(), (sb.meas_count == 0) ? ($urandom_range(0, 3) == 0)
					: ($urandom_range(0, 24) == 0));
				items++;
			end
			wait_idle();
		end

		if (sb.errors == 0 && sb.pending_estimates.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/kmu_pkg.sv
rtl/kmu_ram.sv
rtl/kmu_div.sv
rtl/kmu_dp.sv
rtl/kmu_ctrl.sv
rtl/kalman_measurement_update.sv
dv/tb_top.sv
